>>> sv/ptrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrd_pkg
// Shared types and constants of the periodic task ready dispatcher: field
// widths, the counter width, operation codes and configuration register
// indexes.
// ----------------------------------------------------------------------------
package ptrd_pkg;

  // Number of tasks and the width of a task index.
  localparam int NUM_TASKS = 3;
  localparam int TASK_W    = 2;

  // Width of each periodic down-counter (4 to 32).
  localparam int CNT_W = 8;

  // Beat field widths.
  localparam int OP_W       = 2;
  localparam int INTERVAL_W = 8;
  localparam int REG_IDX_W  = 3;
  localparam int REG_DATA_W = 8;

  // Operation codes of an input beat.
  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 2'd0,
    OP_ASET     = 2'd1,
    OP_DISPATCH = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_INTERVAL_A = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_INTERVAL_B = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_INTERVAL_C = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE     = 3'd3;

  typedef logic [NUM_TASKS-1:0]            flags_t;
  typedef logic [CNT_W-1:0]                cnt_t;
  typedef logic [INTERVAL_W-1:0]           interval_t;

endpackage

>>> sv/ptrd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrd_if
// Valid/ready channel interfaces of the dispatcher: the command input, the
// result output and the configuration write channel.
// ----------------------------------------------------------------------------

interface ptrd_in_if;
  logic                        valid;
  logic                        ready;
  logic [ptrd_pkg::OP_W-1:0]   opcode;
  logic [ptrd_pkg::TASK_W-1:0] task_index;

  modport source (output valid, output opcode, output task_index, input ready);
  modport sink   (input valid, input opcode, input task_index, output ready);
endinterface

interface ptrd_out_if;
  logic                           valid;
  logic                           ready;
  logic                           grant_valid;
  logic [ptrd_pkg::TASK_W-1:0]    granted_task;
  logic [ptrd_pkg::NUM_TASKS-1:0] ready_flags;

  modport source (output valid, output grant_valid, output granted_task,
                  output ready_flags, input ready);
  modport sink   (input valid, input grant_valid, input granted_task,
                  input ready_flags, output ready);
endinterface

interface ptrd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ptrd_pkg::REG_IDX_W-1:0]  index;
  logic [ptrd_pkg::REG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/periodic_task_ready_dispatcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_ready_dispatcher_top
// Tick-driven fixed-priority dispatcher for three periodic tasks. Each task
// has a down-counter and a ready flag; ticks run the counters, async sets
// raise flags and dispatch requests grant the lowest-numbered ready task.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Beat contents
// in_ch     in   opcode, task_index
// out_ch    out  grant_valid, granted_task, ready_flags (one per input beat)
// cfg_ch    in   index, data (register write, always accepted)
//
// One beat per cycle unless out_ch stalls: a beat goes through the input
// and result registers to out_ch, with no bubble between back-to-back beats.
// Task state is updated in the one combinational step between the input
// and result registers, so each beat sees the state its predecessor left.
// An out_ch stall holds the result; in_ch.ready drops only when both are full.
// rst_n (synchronous, active low) clears all task state and both valid bits.
// ----------------------------------------------------------------------------
module periodic_task_ready_dispatcher_top (
  input  logic       clk,
  input  logic       rst_n,
  ptrd_in_if.sink    in_ch,
  ptrd_out_if.source out_ch,
  ptrd_cfg_if.sink   cfg_ch
);

  // Input register: holds one accepted command beat.
  logic                          in_v_r;
  logic [ptrd_pkg::OP_W-1:0]     op_r;
  logic [ptrd_pkg::TASK_W-1:0]   tidx_r;

  // Result register.
  logic                          out_v_r;
  logic                          gv_r, gv_nxt;
  logic [ptrd_pkg::TASK_W-1:0]   gt_r, gt_nxt;
  ptrd_pkg::flags_t              flags_out_r;

  // Task state and configuration.
  ptrd_pkg::cnt_t      [ptrd_pkg::NUM_TASKS-1:0] cnt_r, cnt_nxt;
  ptrd_pkg::interval_t [ptrd_pkg::NUM_TASKS-1:0] interval_r, interval_nxt;
  ptrd_pkg::flags_t                              enable_r, enable_nxt;
  ptrd_pkg::flags_t                              ready_r, ready_nxt;

  logic adv;
  logic in_fire;
  logic cfg_fire;
  ptrd_pkg::cnt_t dec_cnt;

  // The beat in the input register moves on when the result register is
  // free or is being emptied this cycle.
  assign adv      = in_v_r && (!out_v_r || out_ch.ready);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;

  assign in_ch.ready  = !in_v_r || adv;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_v_r;
  assign out_ch.grant_valid  = gv_r;
  assign out_ch.granted_task = gt_r;
  assign out_ch.ready_flags  = flags_out_r;

  // Next task state for the beat leaving the input register, followed by any
  // configuration write (the user must write only while the block is idle).
  always_comb begin
    cnt_nxt      = cnt_r;
    interval_nxt = interval_r;
    enable_nxt   = enable_r;
    ready_nxt    = ready_r;
    gv_nxt       = 1'b0;
    gt_nxt       = '0;
    dec_cnt      = '0;

    if (adv) begin
      case (ptrd_pkg::op_t'(op_r))
        ptrd_pkg::OP_TICK: begin
          for (int i = 0; i < ptrd_pkg::NUM_TASKS; i++) begin
            if (enable_r[i]) begin
              dec_cnt = cnt_r[i] - ptrd_pkg::cnt_t'(1);
              if (dec_cnt == '0) begin
                // Reload; a zero interval reloads zero, giving a full wrap.
                cnt_nxt[i]   = ptrd_pkg::CNT_W'(interval_r[i]);
                ready_nxt[i] = 1'b1;
              end else begin
                cnt_nxt[i] = dec_cnt;
              end
            end
          end
        end
        ptrd_pkg::OP_ASET: begin
          // An out-of-range task index is ignored.
          if (tidx_r < ptrd_pkg::TASK_W'(ptrd_pkg::NUM_TASKS)) begin
            ready_nxt[tidx_r] = 1'b1;
          end
        end
        ptrd_pkg::OP_DISPATCH: begin
          // Scan from the top so the lowest ready index wins.
          for (int i = ptrd_pkg::NUM_TASKS - 1; i >= 0; i--) begin
            if (ready_r[i]) begin
              gv_nxt = 1'b1;
              gt_nxt = ptrd_pkg::TASK_W'(i);
            end
          end
          if (gv_nxt) begin
            ready_nxt[gt_nxt] = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    if (cfg_fire) begin
      unique case (cfg_ch.index) inside
        ptrd_pkg::REG_INTERVAL_A, ptrd_pkg::REG_INTERVAL_B,
        ptrd_pkg::REG_INTERVAL_C: begin
          interval_nxt[cfg_ch.index[ptrd_pkg::TASK_W-1:0]] =
            ptrd_pkg::INTERVAL_W'(cfg_ch.data);
          cnt_nxt[cfg_ch.index[ptrd_pkg::TASK_W-1:0]] =
            ptrd_pkg::CNT_W'(cfg_ch.data);
        end
        ptrd_pkg::REG_ENABLE: begin
          enable_nxt = cfg_ch.data[ptrd_pkg::NUM_TASKS-1:0];
        end
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

  // Control and task state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      cnt_r      <= '0;
      interval_r <= '0;
      enable_r   <= '0;
      ready_r    <= '0;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_fire;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      cnt_r      <= cnt_nxt;
      interval_r <= interval_nxt;
      enable_r   <= enable_nxt;
      ready_r    <= ready_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_ch.opcode;
      tidx_r <= in_ch.task_index;
    end
    if (adv) begin
      gv_r        <= gv_nxt;
      gt_r        <= gt_nxt;
      flags_out_r <= ready_nxt;
    end
  end

`ifndef SYNTHESIS
  // A dispatch that finds any ready task must report a grant.
  a_dispatch_grants: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (op_r == ptrd_pkg::OP_DISPATCH) && (ready_r != '0) |=> gv_r)
    else $error("dispatch with a ready task produced no grant");

  // Only a dispatch may report a grant.
  a_grant_only_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (op_r != ptrd_pkg::OP_DISPATCH) |=> !gv_r)
    else $error("grant reported for a non-dispatch beat");

  // Outside a dispatch, ready flags are never cleared.
  a_flags_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (op_r != ptrd_pkg::OP_DISPATCH)
      |=> ((ready_r & $past(ready_r)) == $past(ready_r)))
    else $error("ready flag cleared without a dispatch");
`endif

endmodule
